>>> rtl/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int WORD_W    = 32;
    localparam int OPND_W    = WORD_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int PIX_W     = 10;
    localparam int SIDE_W    = 11;
    localparam int LIMIT_W   = 16;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [SIDE_W-1:0] MAX_SIDE = 11'd1024;
    localparam logic [SIDE_W-1:0] MIN_SIDE = 11'd1;

    localparam logic signed [WORD_W:0] ESC_BOUND = 33'sd4 <<< FRAC_BITS;

    localparam logic [2:0] REG_REAL_MIN   = 3'd0;
    localparam logic [2:0] REG_REAL_MAX   = 3'd1;
    localparam logic [2:0] REG_IMAG_MIN   = 3'd2;
    localparam logic [2:0] REG_IMAG_MAX   = 3'd3;
    localparam logic [2:0] REG_IMAGE_SIDE = 3'd4;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd5;

    localparam logic [WORD_W-1:0]  RST_REAL_MIN   = 32'hF000_0000;
    localparam logic [WORD_W-1:0]  RST_REAL_MAX   = 32'h1000_0000;
    localparam logic [WORD_W-1:0]  RST_IMAG_MIN   = 32'hF000_0000;
    localparam logic [WORD_W-1:0]  RST_IMAG_MAX   = 32'h1000_0000;
    localparam logic [SIDE_W-1:0]  RST_IMAGE_SIDE = 11'd600;
    localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 16'd255;

    localparam logic [WORD_W-1:0] WORD_POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_NEG_MAX = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [WORD_W-1:0]  real_min;
        logic [WORD_W-1:0]  real_max;
        logic [WORD_W-1:0]  imag_min;
        logic [WORD_W-1:0]  imag_max;
        logic [SIDE_W-1:0]  image_side;
        logic [LIMIT_W-1:0] iteration_limit;
    } mbe_cfg_t;

    function automatic logic [WORD_W-1:0] sat_34(input logic [WORD_W+1:0] v);
        logic ovf;
        ovf = (v[WORD_W+1:WORD_W-1] != 3'b000) && (v[WORD_W+1:WORD_W-1] != 3'b111);
        if (ovf)
            return v[WORD_W+1] ? WORD_NEG_MAX : WORD_POS_MAX;
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] sat_45(input logic [44:0] v);
        logic ovf;
        ovf = (v[44:WORD_W-1] != '0) && (v[44:WORD_W-1] != '1);
        if (ovf)
            return v[44] ? WORD_NEG_MAX : WORD_POS_MAX;
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] q_fix(input logic [PROD_W-1:0] p);
        logic [PROD_W-FRAC_BITS-1:0] q;
        logic                        rnd;
        rnd = p[PROD_W-1] & (|p[FRAC_BITS-1:0]);
        q   = p[PROD_W-1:FRAC_BITS] + {{(PROD_W-FRAC_BITS-1){1'b0}}, rnd};
        if ((q[PROD_W-FRAC_BITS-1:WORD_W-1] != '0) && (q[PROD_W-FRAC_BITS-1:WORD_W-1] != '1))
            return q[PROD_W-FRAC_BITS-1] ? WORD_NEG_MAX : WORD_POS_MAX;
        return q[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/mbe_regs.sv
`default_nettype none

module mbe_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mbe_pkg::DATA_W-1:0]  pwdata,
    output logic      [mbe_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output mbe_pkg::mbe_cfg_t                cfg
);
    import mbe_pkg::*;

    mbe_cfg_t   cfg_reg;
    logic [2:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_min        <= RST_REAL_MIN;
            cfg_reg.real_max        <= RST_REAL_MAX;
            cfg_reg.imag_min        <= RST_IMAG_MIN;
            cfg_reg.imag_max        <= RST_IMAG_MAX;
            cfg_reg.image_side      <= RST_IMAGE_SIDE;
            cfg_reg.iteration_limit <= RST_ITER_LIMIT;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_REAL_MIN:   cfg_reg.real_min        <= pwdata;
                REG_REAL_MAX:   cfg_reg.real_max        <= pwdata;
                REG_IMAG_MIN:   cfg_reg.imag_min        <= pwdata;
                REG_IMAG_MAX:   cfg_reg.imag_max        <= pwdata;
                REG_IMAGE_SIDE: cfg_reg.image_side      <= pwdata[SIDE_W-1:0];
                REG_ITER_LIMIT: cfg_reg.iteration_limit <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_REAL_MIN:   prdata = cfg_reg.real_min;
            REG_REAL_MAX:   prdata = cfg_reg.real_max;
            REG_IMAG_MIN:   prdata = cfg_reg.imag_min;
            REG_IMAG_MAX:   prdata = cfg_reg.imag_max;
            REG_IMAGE_SIDE: prdata = {{(DATA_W-SIDE_W){1'b0}}, cfg_reg.image_side};
            REG_ITER_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_reg.iteration_limit};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/mbe_div.sv
`default_nettype none

module mbe_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mbe_pkg::WORD_W:0]      dividend_a,
    input  wire logic [mbe_pkg::WORD_W:0]      dividend_b,
    input  wire logic [mbe_pkg::SIDE_W-1:0]    divisor,
    output logic      [mbe_pkg::WORD_W:0]      quot_a,
    output logic      [mbe_pkg::WORD_W:0]      quot_b,
    output logic                               done
);
    import mbe_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [SIDE_W-1:0]    dsr_reg, dsr_next;
    logic [SIDE_W-1:0]    rem_reg [2];
    logic [SIDE_W-1:0]    rem_next [2];
    logic [WORD_W-1:0]    mag_reg [2];
    logic [WORD_W-1:0]    mag_next [2];
    logic                 neg_reg [2];
    logic                 neg_next [2];
    logic [WORD_W:0]      dvd [2];
    logic [WORD_W:0]      dvd_abs [2];
    logic [SIDE_W:0]      rem_sh [2];
    logic [SIDE_W:0]      rem_sub [2];

    assign dvd[0] = dividend_a;
    assign dvd[1] = dividend_b;
    assign done   = done_reg;
    assign quot_a = neg_reg[0] ? -{1'b0, mag_reg[0]} : {1'b0, mag_reg[0]};
    assign quot_b = neg_reg[1] ? -{1'b0, mag_reg[1]} : {1'b0, mag_reg[1]};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        for (int i = 0; i < 2; i++)
        begin
            dvd_abs[i]  = dvd[i][WORD_W] ? -dvd[i] : dvd[i];
            rem_sh[i]   = {rem_reg[i], mag_reg[i][WORD_W-1]};
            rem_sub[i]  = rem_sh[i] - {1'b0, dsr_reg};
            rem_next[i] = rem_reg[i];
            mag_next[i] = mag_reg[i];
            neg_next[i] = neg_reg[i];
            if (start)
            begin
                rem_next[i] = '0;
                mag_next[i] = dvd_abs[i][WORD_W-1:0];
                neg_next[i] = dvd[i][WORD_W];
            end
            else if (run_reg)
            begin
                if (!rem_sub[i][SIDE_W])
                begin
                    rem_next[i] = rem_sub[i][SIDE_W-1:0];
                    mag_next[i] = {mag_reg[i][WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_sh[i][SIDE_W-1:0];
                    mag_next[i] = {mag_reg[i][WORD_W-2:0], 1'b0};
                end
            end
        end
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsr_reg <= dsr_next;
        for (int i = 0; i < 2; i++)
        begin
            rem_reg[i] <= rem_next[i];
            mag_reg[i] <= mag_next[i];
            neg_reg[i] <= neg_next[i];
        end
    end

endmodule

`default_nettype wire

>>> rtl/mbe_mul.sv
`default_nettype none

module mbe_mul (
    input  wire logic                               clk,
    input  wire logic signed [mbe_pkg::OPND_W-1:0]  a,
    input  wire logic signed [mbe_pkg::OPND_W-1:0]  b,
    output logic             [mbe_pkg::PROD_W-1:0]  prod
);
    import mbe_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = a * b;
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

>>> rtl/mandelbrot_escape_time.sv
`default_nettype none

// Start-up runs a shift-subtract divide for the span steps, then the mapping states
// S_MAP_R, S_MAP_I and S_MAP_C; each iteration then steps through S_IT_A to S_IT_D
// on one 33x33 multiplier. A new pixel is taken only while idle; busy drops with the
// done strobe, and the receiver cannot stall. Reset: asynchronous, active low; idle, default registers.
module mandelbrot_escape_time (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mbe_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mbe_pkg::DATA_W-1:0]    pwdata,
    output logic      [mbe_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          start,
    input  wire logic [mbe_pkg::PIX_W-1:0]     pixel_x,
    input  wire logic [mbe_pkg::PIX_W-1:0]     pixel_y,
    output logic                               busy,
    output logic                               done,
    output logic      [mbe_pkg::LIMIT_W-1:0]   escape_count,
    output logic      [7:0]                    red_level,
    output logic      [7:0]                    green_level,
    output logic      [7:0]                    blue_level
);
    import mbe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MAP_R,
        S_MAP_I,
        S_MAP_C,
        S_IT_A,
        S_IT_B,
        S_IT_C,
        S_IT_D
    } state_t;

    mbe_cfg_t             cfg;
    state_t               state_reg, state_next;
    logic                 done_reg, done_next;
    logic [LIMIT_W-1:0]   count_reg, count_next;
    logic [7:0]           green_reg, green_next;

    logic [PIX_W-1:0]     px_reg, px_next;
    logic [PIX_W-1:0]     py_reg, py_next;
    logic [WORD_W-1:0]    cr_reg, cr_next;
    logic [WORD_W-1:0]    ci_reg, ci_next;
    logic [WORD_W-1:0]    zr_reg, zr_next;
    logic [WORD_W-1:0]    zi_reg, zi_next;
    logic [WORD_W-1:0]    zr2_reg, zr2_next;
    logic [WORD_W-1:0]    zi2_reg, zi2_next;
    logic [LIMIT_W-1:0]   n_reg, n_next;

    logic                 accept;
    logic                 div_done;
    logic [SIDE_W-1:0]    side_eff;
    logic [WORD_W:0]      span_r;
    logic [WORD_W:0]      span_i;
    logic [WORD_W:0]      step_r;
    logic [WORD_W:0]      step_i;
    logic [OPND_W-1:0]    mul_a;
    logic [OPND_W-1:0]    mul_b;
    logic [PROD_W-1:0]    prod;
    logic [WORD_W-1:0]    prod_q;
    logic [44:0]          map_sum_r;
    logic [44:0]          map_sum_i;
    logic [WORD_W:0]      mag_sum;
    logic [WORD_W+1:0]    zr_new;
    logic [WORD_W+1:0]    zi_new;
    logic [15:0]          n_sq;

    mbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        if (cfg.image_side == '0)
            side_eff = MIN_SIDE;
        else if (cfg.image_side > MAX_SIDE)
            side_eff = MAX_SIDE;
        else
            side_eff = cfg.image_side;
    end

    assign span_r = {cfg.real_max[WORD_W-1], cfg.real_max}
                  - {cfg.real_min[WORD_W-1], cfg.real_min};
    assign span_i = {cfg.imag_max[WORD_W-1], cfg.imag_max}
                  - {cfg.imag_min[WORD_W-1], cfg.imag_min};

    mbe_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .dividend_a (span_r),
        .dividend_b (span_i),
        .divisor    (side_eff),
        .quot_a     (step_r),
        .quot_b     (step_i),
        .done       (div_done)
    );

    mbe_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        case (state_reg)
            S_MAP_R:
            begin
                mul_a = {{(OPND_W-PIX_W){1'b0}}, px_reg};
                mul_b = step_r;
            end
            S_MAP_I:
            begin
                mul_a = {{(OPND_W-PIX_W){1'b0}}, py_reg};
                mul_b = step_i;
            end
            S_IT_A:
            begin
                mul_a = {zr_reg[WORD_W-1], zr_reg};
                mul_b = {zr_reg[WORD_W-1], zr_reg};
            end
            S_IT_B:
            begin
                mul_a = {zi_reg[WORD_W-1], zi_reg};
                mul_b = {zi_reg[WORD_W-1], zi_reg};
            end
            default:
            begin
                mul_a = {zr_reg[WORD_W-1], zr_reg};
                mul_b = {zi_reg[WORD_W-1], zi_reg};
            end
        endcase
    end

    assign prod_q    = q_fix(prod);
    assign map_sum_r = prod[44:0] + {{(45-WORD_W){cfg.real_min[WORD_W-1]}}, cfg.real_min};
    assign map_sum_i = prod[44:0] + {{(45-WORD_W){cfg.imag_min[WORD_W-1]}}, cfg.imag_min};
    assign mag_sum   = {zr2_reg[WORD_W-1], zr2_reg} + {zi2_reg[WORD_W-1], zi2_reg};
    assign zr_new    = {{2{zr2_reg[WORD_W-1]}}, zr2_reg} - {{2{zi2_reg[WORD_W-1]}}, zi2_reg}
                     + {{2{cr_reg[WORD_W-1]}}, cr_reg};
    assign zi_new    = {prod_q[WORD_W-1], prod_q, 1'b0} + {{2{ci_reg[WORD_W-1]}}, ci_reg};
    assign n_sq      = {8'd0, n_reg[7:0]} * {8'd0, n_reg[7:0]};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        green_next = green_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        zr2_next   = zr2_reg;
        zi2_next   = zi2_reg;
        n_next     = n_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_MAP_R;
            end
            S_MAP_R:
            begin
                state_next = S_MAP_I;
            end
            S_MAP_I:
            begin
                cr_next    = sat_45(map_sum_r);
                state_next = S_MAP_C;
            end
            S_MAP_C:
            begin
                ci_next    = sat_45(map_sum_i);
                zr_next    = '0;
                zi_next    = '0;
                n_next     = '0;
                state_next = S_IT_A;
            end
            S_IT_A:
            begin
                if (n_reg == cfg.iteration_limit)
                begin
                    done_next  = 1'b1;
                    count_next = n_reg;
                    green_next = n_sq[7:0];
                    state_next = S_IDLE;
                end
                else
                    state_next = S_IT_B;
            end
            S_IT_B:
            begin
                zr2_next   = prod_q;
                state_next = S_IT_C;
            end
            S_IT_C:
            begin
                zi2_next   = prod_q;
                state_next = S_IT_D;
            end
            S_IT_D:
            begin
                if ($signed(mag_sum) >= ESC_BOUND)
                begin
                    done_next  = 1'b1;
                    count_next = n_reg;
                    green_next = n_sq[7:0];
                    state_next = S_IDLE;
                end
                else
                begin
                    zr_next    = sat_34(zr_new);
                    zi_next    = sat_34(zi_new);
                    n_next     = n_reg + 16'd1;
                    state_next = S_IT_A;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            green_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            green_reg <= green_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        cr_reg  <= cr_next;
        ci_reg  <= ci_next;
        zr_reg  <= zr_next;
        zi_reg  <= zi_next;
        zr2_reg <= zr2_next;
        zi2_reg <= zi2_next;
        n_reg   <= n_next;
    end

    assign done         = done_reg;
    assign escape_count = count_reg;
    assign red_level    = '0;
    assign green_level  = green_reg;
    assign blue_level   = count_reg[7:0];

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while pixel still in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> escape_count <= cfg.iteration_limit)
        else $error("escape count beyond iteration limit");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not start");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide phase");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mbe_pkg::*;

    typedef struct packed {
        logic [LIMIT_W-1:0] count;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } pixel_color_t;

    typedef struct packed {
        mbe_cfg_t           cfg;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic               known;
        logic [LIMIT_W-1:0] want_count;
        logic [7:0]         want_green;
        logic [7:0]         want_blue;
    } pixel_case_t;

    localparam longint WORD_LIM  = longint'(1) << (FRAC_BITS + 3);
    localparam longint ESC_LEVEL = longint'(4) << FRAC_BITS;
    localparam longint Q28_MAX   = 64'sd2147483647;
    localparam longint Q28_MIN   = -64'sd2147483648;

    localparam mbe_cfg_t RESET_CFG = '{RST_REAL_MIN, RST_REAL_MAX, RST_IMAG_MIN, RST_IMAG_MAX,
                                       RST_IMAGE_SIDE, RST_ITER_LIMIT};
    localparam mbe_cfg_t NO_ITER_CFG = '{32'hF000_0000, 32'h1000_0000, 32'hF000_0000,
                                         32'h1000_0000, 11'd600, 16'd0};
    localparam mbe_cfg_t ONE_ITER_CFG = '{32'hF000_0000, 32'h1000_0000, 32'hF000_0000,
                                          32'h1000_0000, 11'd600, 16'd1};
    localparam mbe_cfg_t ORIGIN_CFG = '{32'h0, 32'h0, 32'h0, 32'h0, 11'd600, 16'd255};
    localparam mbe_cfg_t ORIGIN256_CFG = '{32'h0, 32'h0, 32'h0, 32'h0, 11'd1, 16'd256};
    localparam mbe_cfg_t FAR_CFG = '{32'h7000_0000, 32'h7000_0000, 32'h7000_0000,
                                     32'h7000_0000, 11'd1024, 16'd65535};
    localparam mbe_cfg_t EXTREME_CFG = '{WORD_NEG_MAX, WORD_POS_MAX, WORD_NEG_MAX,
                                         WORD_POS_MAX, 11'd1, 16'd255};
    localparam mbe_cfg_t SIDE0_CFG = '{32'hF000_0000, 32'h1000_0000, 32'hF000_0000,
                                       32'h1000_0000, 11'd0, 16'd255};
    localparam mbe_cfg_t SIDE_HI_CFG = '{32'hF000_0000, 32'h1000_0000, 32'hF000_0000,
                                         32'h1000_0000, 11'd2047, 16'd100};
    localparam mbe_cfg_t REVERSED_CFG = '{32'h1000_0000, 32'hF000_0000, 32'h1000_0000,
                                          32'hF000_0000, 11'd600, 16'd255};
    localparam mbe_cfg_t SIDE16_CFG = '{32'hF000_0000, 32'h1000_0000, 32'hF000_0000,
                                        32'h1000_0000, 11'd16, 16'd255};
    localparam mbe_cfg_t CLASSIC_CFG = '{32'hE000_0000, 32'h0800_0000, 32'hEC00_0000,
                                         32'h1400_0000, 11'd1024, 16'd255};

    localparam int N_DIRECTED = 25;
    localparam int N_PHASES   = 14;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                start = 1'b0;
    logic [PIX_W-1:0]    pixel_x = '0;
    logic [PIX_W-1:0]    pixel_y = '0;
    logic                busy;
    logic                done;
    logic [LIMIT_W-1:0]  escape_count;
    logic [7:0]          red_level;
    logic [7:0]          green_level;
    logic [7:0]          blue_level;

    mbe_cfg_t            cur_cfg;
    pixel_color_t        expected_pixels[$];
    int                  errors = 0;
    int                  idle_pct = 0;
    int                  idle_schedule [3] = '{0, 60, 9};

    pixel_case_t directed_cases [N_DIRECTED] = '{
        '{RESET_CFG,     10'd0,    10'd0,    1'b1, 16'd3,   8'd9, 8'd3},
        '{RESET_CFG,     10'd1023, 10'd1023, 1'b0, 16'd0,   8'd0, 8'd0},
        '{RESET_CFG,     10'd300,  10'd300,  1'b0, 16'd0,   8'd0, 8'd0},
        '{RESET_CFG,     10'd1023, 10'd0,    1'b0, 16'd0,   8'd0, 8'd0},
        '{RESET_CFG,     10'd0,    10'd1023, 1'b0, 16'd0,   8'd0, 8'd0},
        '{NO_ITER_CFG,   10'd512,  10'd512,  1'b1, 16'd0,   8'd0, 8'd0},
        '{NO_ITER_CFG,   10'd1023, 10'd1023, 1'b1, 16'd0,   8'd0, 8'd0},
        '{ONE_ITER_CFG,  10'd0,    10'd0,    1'b1, 16'd1,   8'd1, 8'd1},
        '{ORIGIN_CFG,    10'd0,    10'd0,    1'b1, 16'd255, 8'd1, 8'd255},
        '{ORIGIN_CFG,    10'd1023, 10'd1023, 1'b1, 16'd255, 8'd1, 8'd255},
        '{ORIGIN256_CFG, 10'd5,    10'd5,    1'b1, 16'd256, 8'd0, 8'd0},
        '{FAR_CFG,       10'd0,    10'd0,    1'b1, 16'd1,   8'd1, 8'd1},
        '{FAR_CFG,       10'd1023, 10'd1023, 1'b1, 16'd1,   8'd1, 8'd1},
        '{EXTREME_CFG,   10'd0,    10'd0,    1'b1, 16'd1,   8'd1, 8'd1},
        '{EXTREME_CFG,   10'd1023, 10'd1023, 1'b1, 16'd1,   8'd1, 8'd1},
        '{EXTREME_CFG,   10'd1,    10'd0,    1'b0, 16'd0,   8'd0, 8'd0},
        '{SIDE0_CFG,     10'd0,    10'd1,    1'b0, 16'd0,   8'd0, 8'd0},
        '{SIDE0_CFG,     10'd1023, 10'd1,    1'b0, 16'd0,   8'd0, 8'd0},
        '{SIDE_HI_CFG,   10'd1023, 10'd1023, 1'b0, 16'd0,   8'd0, 8'd0},
        '{SIDE_HI_CFG,   10'd512,  10'd700,  1'b0, 16'd0,   8'd0, 8'd0},
        '{REVERSED_CFG,  10'd0,    10'd0,    1'b0, 16'd0,   8'd0, 8'd0},
        '{REVERSED_CFG,  10'd200,  10'd450,  1'b0, 16'd0,   8'd0, 8'd0},
        '{SIDE16_CFG,    10'd1023, 10'd5,    1'b0, 16'd0,   8'd0, 8'd0},
        '{CLASSIC_CFG,   10'd512,  10'd512,  1'b0, 16'd0,   8'd0, 8'd0},
        '{CLASSIC_CFG,   10'd700,  10'd300,  1'b0, 16'd0,   8'd0, 8'd0}
    };

    mandelbrot_escape_time DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .busy         (busy),
        .done         (done),
        .escape_count (escape_count),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clip_word(longint v);
        if (v > WORD_LIM - 1)
            return WORD_LIM - 1;
        if (v < -WORD_LIM)
            return -WORD_LIM;
        return v;
    endfunction

    function automatic longint q_mult(longint a, longint b);
        longint ma;
        longint mb;
        longint q;
        bit     neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        q   = (ma * mb) >> FRAC_BITS;
        if (neg)
            return (q > WORD_LIM) ? -WORD_LIM : -q;
        return (q > WORD_LIM - 1) ? WORD_LIM - 1 : q;
    endfunction

    function automatic longint map_axis(logic [PIX_W-1:0] pix, logic [31:0] lo_w,
                                        logic [31:0] hi_w, longint side);
        longint lo;
        longint hi;
        longint step;
        longint c;
        lo   = $signed(lo_w);
        hi   = $signed(hi_w);
        step = (hi - lo) / side;
        c    = longint'(pix) * step + lo;
        if (c > Q28_MAX)
            c = Q28_MAX;
        if (c < Q28_MIN)
            c = Q28_MIN;
        return c;
    endfunction

    function automatic pixel_color_t shade_pixel(mbe_cfg_t cfg, logic [PIX_W-1:0] x,
                                                 logic [PIX_W-1:0] y);
        longint       side;
        longint       cr;
        longint       ci;
        longint       zr;
        longint       zi;
        longint       zr2;
        longint       zi2;
        longint       t;
        int unsigned  n;
        logic [31:0]  sq;
        pixel_color_t res;
        side = longint'(cfg.image_side);
        if (side < longint'(MIN_SIDE))
            side = longint'(MIN_SIDE);
        if (side > longint'(MAX_SIDE))
            side = longint'(MAX_SIDE);
        cr = map_axis(x, cfg.real_min, cfg.real_max, side);
        ci = map_axis(y, cfg.imag_min, cfg.imag_max, side);
        zr = 0;
        zi = 0;
        n  = 0;
        while (n < cfg.iteration_limit)
        begin
            zr2 = q_mult(zr, zr);
            zi2 = q_mult(zi, zi);
            if (zr2 + zi2 >= ESC_LEVEL)
                break;
            t  = clip_word(zr2 - zi2 + cr);
            zi = clip_word(2 * q_mult(zr, zi) + ci);
            zr = t;
            n++;
        end
        sq        = n * n;
        res.count = n[LIMIT_W-1:0];
        res.red   = 8'd0;
        res.green = sq[7:0];
        res.blue  = n[7:0];
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        pixel_color_t want;
        if (done === 1'b1)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got count %0d",
                         $time, escape_count);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("escape_count", want.count, escape_count);
                check_field("red_level", {8'd0, want.red}, {8'd0, red_level});
                check_field("green_level", {8'd0, want.green}, {8'd0, green_level});
                check_field("blue_level", {8'd0, want.blue}, {8'd0, blue_level});
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic load_config(mbe_cfg_t c);
        apb_write(REG_REAL_MIN, c.real_min);
        apb_write(REG_REAL_MAX, c.real_max);
        apb_write(REG_IMAG_MIN, c.imag_min);
        apb_write(REG_IMAG_MAX, c.imag_max);
        apb_write(REG_IMAGE_SIDE, {21'd0, c.image_side});
        apb_write(REG_ITER_LIMIT, {16'd0, c.iteration_limit});
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_cfg = c;
    endtask

    // hold start low and wait until every pending pixel is back and the engine is idle
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_pixels.size() != 0 || busy !== 1'b0);
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, pixel_color_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        expected_pixels.push_back(want);
    endtask

    initial
    begin
        #(30_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        mbe_cfg_t     cfg;
        pixel_case_t  row;
        pixel_color_t want;
        logic [31:0]  span [4];
        int           kind;
        int           n_items;
        int           eff_side;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;

        cur_cfg = RESET_CFG;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 0;
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = directed_cases[r];
            if (row.cfg != cur_cfg)
            begin
                settle();
                load_config(row.cfg);
            end
            if (row.known)
                want = '{row.want_count, 8'd0, row.want_green, row.want_blue};
            else
                want = shade_pixel(cur_cfg, row.pixel_x, row.pixel_y);
            send_pixel(row.pixel_x, row.pixel_y, want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            idle_pct = idle_schedule[p % 3];
            kind = (p == 5 || p == 9) ? 0 : $urandom_range(4);
            for (int k = 0; k < 4; k++)
            begin
                case (kind)
                    0, 1, 2:
                    begin
                        if (k == 0)
                            span[k] = -$urandom_range(32'h2800_0000, 32'h0400_0000);
                        else if (k == 1)
                            span[k] = $urandom_range(32'h1000_0000, 0);
                        else if (k == 2)
                            span[k] = -$urandom_range(32'h1800_0000, 0);
                        else
                            span[k] = $urandom_range(32'h1800_0000, 0);
                    end
                    3:
                        span[k] = $urandom;
                    default:
                    begin
                        case ($urandom_range(3))
                            0: span[k] = WORD_NEG_MAX;
                            1: span[k] = WORD_POS_MAX;
                            2: span[k] = 32'h0;
                            default: span[k] = $urandom;
                        endcase
                    end
                endcase
            end
            // reverse the span direction
            if (kind == 2)
            begin
                cfg.real_min = span[1];
                cfg.real_max = span[0];
                cfg.imag_min = span[3];
                cfg.imag_max = span[2];
            end
            else
            begin
                cfg.real_min = span[0];
                cfg.real_max = span[1];
                cfg.imag_min = span[2];
                cfg.imag_max = span[3];
            end
            case ($urandom_range(7))
                0: cfg.image_side = 11'd0;
                1: cfg.image_side = 11'd1;
                2: cfg.image_side = MAX_SIDE;
                3: cfg.image_side = 11'($urandom_range(2047, 1025));
                4, 5: cfg.image_side = 11'($urandom_range(128, 16));
                default: cfg.image_side = 11'($urandom_range(1024, 1));
            endcase
            if (p == 5)
                cfg.iteration_limit = 16'd255;
            else if (p == 9)
                cfg.iteration_limit = 16'($urandom_range(700, 300));
            else if ($urandom_range(9) == 0)
                cfg.iteration_limit = 16'($urandom_range(1));
            else
                cfg.iteration_limit = 16'($urandom_range(40, 2));
            settle();
            load_config(cfg);

            eff_side = cfg.image_side;
            if (eff_side < 1)
                eff_side = 1;
            if (eff_side > 1024)
                eff_side = 1024;
            n_items = (p == 5) ? 60 : (p == 9) ? 20 : 150;
            for (int i = 0; i < n_items; i++)
            begin
                if (i == n_items / 2)
                    settle();
                if ($urandom_range(3) == 0)
                begin
                    px = 10'($urandom_range(1023));
                    py = 10'($urandom_range(1023));
                end
                else
                begin
                    px = 10'($urandom_range(eff_side - 1, 0));
                    py = 10'($urandom_range(eff_side - 1, 0));
                end
                send_pixel(px, py, shade_pixel(cur_cfg, px, py));
            end
        end

        settle();
        repeat (64)
            @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
